/* hdl/odd_pkg.sv */
// Shared types, constants and helper functions for the OFDM deinterleaver
// and depuncturer. No dependencies; every other file of the block imports it.
package odd_pkg;

  localparam int DATA_CARRIERS = 48;
  localparam int BANK_DEPTH    = DATA_CARRIERS * 6;
  localparam int POS_W         = $clog2(BANK_DEPTH);
  localparam int CNT_W         = $clog2(BANK_DEPTH + 1);
  localparam int PHASE_W       = 3;

  typedef enum logic [1:0] {
    MOD_BPSK  = 2'd0,
    MOD_QPSK  = 2'd1,
    MOD_16QAM = 2'd2,
    MOD_64QAM = 2'd3
  } modulation_e;

  typedef enum logic [1:0] {
    CMD_BIT   = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_START = 2'd2
  } command_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_e;

  localparam logic CFG_MODULATION = 1'b0;
  localparam logic CFG_CODE_RATE  = 1'b1;

  localparam logic [1:0] SYM_ERASURE = 2'd2;

  // Puncturing patterns, bit p is position p; an unused rate code falls back to 1/2.
  localparam logic [5:0] RATE_PATTERN [4] = '{6'b000011, 6'b000111, 6'b100111, 6'b000011};
  localparam logic [PHASE_W-1:0] RATE_PERIOD [4] = '{3'd2, 3'd4, 3'd6, 3'd2};

  typedef struct packed {
    logic [1:0]         lead;
    logic [1:0]         trail;
    logic [PHASE_W-1:0] next_phase;
  } plan_t;

  typedef struct packed {
    logic [1:0] lead;
    logic [1:0] trail;
    logic       done;
  } dp_req_t;

  function automatic logic [CNT_W-1:0] ncbps_of(modulation_e m);
    logic [CNT_W-1:0] n;
    unique case (m)
      MOD_BPSK:  n = CNT_W'(DATA_CARRIERS * 1);
      MOD_QPSK:  n = CNT_W'(DATA_CARRIERS * 2);
      MOD_16QAM: n = CNT_W'(DATA_CARRIERS * 4);
      MOD_64QAM: n = CNT_W'(DATA_CARRIERS * 6);
      default:   n = CNT_W'(DATA_CARRIERS * 1);
    endcase
    return n;
  endfunction

  function automatic logic [PHASE_W-1:0] phase_step(logic [PHASE_W-1:0] p,
                                                    logic [PHASE_W-1:0] period);
    logic [PHASE_W-1:0] nxt;
    nxt = p + PHASE_W'(1);
    return (nxt == period) ? '0 : nxt;
  endfunction

  // Erasures before and after the received bit, and the phase that follows.
  function automatic plan_t depunct_plan(logic [1:0] rate, logic [PHASE_W-1:0] phase);
    plan_t              pl;
    logic [PHASE_W-1:0] p;
    logic [PHASE_W-1:0] period;
    period   = RATE_PERIOD[rate];
    p        = (phase >= period) ? '0 : phase;
    pl.lead  = '0;
    pl.trail = '0;
    for (int n = 0; n < 2; n++) begin
      if (!RATE_PATTERN[rate][p]) begin
        pl.lead = pl.lead + 2'd1;
        p       = phase_step(p, period);
      end
    end
    p = phase_step(p, period);
    for (int n = 0; n < 2; n++) begin
      if (!RATE_PATTERN[rate][p]) begin
        pl.trail = pl.trail + 2'd1;
        p        = phase_step(p, period);
      end
    end
    pl.next_phase = p;
    return pl;
  endfunction

  // Exact floor(x / 3) for x below 2048.
  function automatic logic [POS_W-1:0] div3(logic [POS_W-1:0] x);
    logic [POS_W+10:0] prod;
    prod = (POS_W + 11)'(x) * (POS_W + 11)'(683);
    return prod[POS_W+10:11] & POS_W'({POS_W{1'b1}});
  endfunction

endpackage

/* hdl/odd_addr.sv */
// Two-stage deinterleaver address unit: first stage registers the quotients
// of the write position, second stage forms the bank address. Uses odd_pkg.
module odd_addr (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic [odd_pkg::POS_W-1:0] pos_i,
  input  odd_pkg::modulation_e     mod_i,
  output logic [odd_pkg::POS_W-1:0] addr_o
);
  import odd_pkg::*;

  logic [POS_W-1:0]  j_q;
  logic [POS_W-1:0]  jd3_q;
  logic [3:0]        t_q;
  logic [POS_W-1:0]  jd3;
  logic [POS_W+5:0]  jd9_prod;
  logic [3:0]        t;

  logic [POS_W-1:0]  i_val;
  logic [POS_W-1:0]  jd3x3;
  logic [1:0]        jm3;
  logic [7:0]        t11;
  logic [3:0]        tm3;
  logic [2:0]        rsum;
  logic [1:0]        rmod;
  logic [CNT_W-1:0]  ncbps_m1;
  logic [POS_W+3:0]  i16;
  logic [POS_W+3:0]  wrap;
  logic [POS_W+3:0]  kdiff;

  // j / D with D = N_CBPS / 16, which is 3, 6, 12 or 18
  always_comb begin
    jd3      = div3(pos_i);
    jd9_prod = (POS_W + 6)'(pos_i) * (POS_W + 6)'(57);
    unique case (mod_i)
      MOD_BPSK:  t = jd3[3:0];
      MOD_QPSK:  t = jd3[4:1];
      MOD_16QAM: t = jd3[5:2];
      MOD_64QAM: t = jd9_prod[POS_W+4:POS_W+1];
      default:   t = jd3[3:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      j_q   <= pos_i;
      jd3_q <= jd3;
      t_q   <= t;
    end
  end

  // Second permutation step; floor(i / D) equals j / D, so t serves both steps.
  always_comb begin
    jd3x3 = POS_W'({jd3_q, 1'b0}) + jd3_q;
    jm3   = 2'(j_q - jd3x3);
    t11   = 8'(t_q) * 8'd11;
    tm3   = t_q - 4'(3 * t11[7:5]);
    rsum  = 3'(jm3) + 3'(tm3);
    rmod  = (rsum >= 3'd3) ? 2'(rsum - 3'd3) : rsum[1:0];
    unique case (mod_i)
      MOD_BPSK,
      MOD_QPSK:  i_val = j_q;
      MOD_16QAM: i_val = {j_q[POS_W-1:1], j_q[0] ^ t_q[0]};
      MOD_64QAM: i_val = jd3x3 + POS_W'(rmod);
      default:   i_val = j_q;
    endcase
    ncbps_m1 = ncbps_of(mod_i) - CNT_W'(1);
    i16      = {i_val, 4'b0000};
    wrap     = (POS_W + 4)'(ncbps_m1) * (POS_W + 4)'(t_q);
    kdiff    = i16 - wrap;
    addr_o   = kdiff[POS_W-1:0];
  end

endmodule

/* hdl/odd_bank.sv */
// Two symbol banks of one-bit entries in a single synchronous memory with
// one write port and one registered read port. Uses odd_pkg.
module odd_bank (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic                     wr_bank_i,
  input  logic [odd_pkg::POS_W-1:0] wr_pos_i,
  input  logic                     wr_bit_i,
  input  logic                     rd_en_i,
  input  logic                     rd_bank_i,
  input  logic [odd_pkg::POS_W-1:0] rd_pos_i,
  output logic                     rd_bit_o
);
  import odd_pkg::*;

  logic mem_q [2][BANK_DEPTH];
  logic rd_bit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_bank_i][wr_pos_i] <= wr_bit_i;
    end
  end

  // Hold the last read until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_bit_q <= mem_q[rd_bank_i][rd_pos_i];
    end
  end

  assign rd_bit_o = rd_bit_q;

endmodule

/* hdl/odd_depunct.sv */
// Depuncturing output stage: emits leading erasures, the received bit and
// trailing erasures, one result per cycle while out_ready_i is high. Uses odd_pkg.
module odd_depunct (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  odd_pkg::dp_req_t req_i,
  input  logic             bit_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       symbol_o,
  output logic             symbol_done_o,
  output logic             last_o,
  output logic             free_o
);
  import odd_pkg::*;

  logic       busy_q;
  logic [1:0] idx_q;
  logic [1:0] lead_q;
  logic [1:0] last_idx_q;
  logic       bit_q;
  logic       done_q;
  logic       last;

  assign last = (idx_q == last_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lead_q     <= req_i.lead;
      last_idx_q <= req_i.lead + req_i.trail;
      bit_q      <= bit_i;
      done_q     <= req_i.done;
    end
  end

  assign free_o        = !busy_q || (out_ready_i && last);
  assign out_valid_o   = busy_q;
  assign symbol_o      = (idx_q == lead_q) ? {1'b0, bit_q} : SYM_ERASURE;
  assign symbol_done_o = done_q && last;
  assign last_o        = last;

endmodule

/* hdl/ofdm_deinterleave_depuncture.sv */
// Top level of the OFDM deinterleaver and depuncturer; instantiates odd_addr,
// odd_bank and odd_depunct, and uses odd_pkg.
//
// Coded bits enter one per request and are written into the filling symbol
// bank at the 802.11a deinterleaver address for the configured modulation;
// on the same request one position of the previously completed symbol is read
// back in natural order and depunctured into one to three results (erasures
// are code 2). A drain request reads without writing, a frame start request
// clears positions, bank selection and puncturing phase. Flow: a request
// that reads or writes is accepted, then holds a load state while the
// memory read returns and the write lands; after a read the load state
// stalls until the single output stage, which emits one result per cycle
// while out_ready_i is high, can take the new run; no request is accepted
// meanwhile. Requests with no memory access (frame start, drain with
// nothing held, the unused command) skip the load state. The banks are
// not cleared at reset and need no clearing pass. Write modulation and
// code_rate only while no request is in flight.
module ofdm_deinterleave_depuncture (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic       coded_bit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] decoded_symbol_o,
  output logic       symbol_done_o,
  output logic       last_of_run_o
);
  import odd_pkg::*;

  // control and configuration state
  state_e             state_q, state_d;
  modulation_e        mod_q;
  logic [1:0]         rate_q;
  logic [POS_W-1:0]   wp_q, wp_d;
  logic [POS_W-1:0]   rp_q, rp_d;
  logic               bank_q, bank_d;
  logic               held_q, held_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               has_read_q, has_read_d;
  logic               wr_pend_q, wr_pend_d;

  // request payload carried into the load cycle
  logic               wbank_q;
  logic               wbit_q;
  dp_req_t            req_q, req_d;

  logic               accept;
  logic               rd_en;
  logic               addr_load;
  logic [POS_W-1:0]   j_pos;
  logic [CNT_W-1:0]   ncbps;
  logic [CNT_W-1:0]   rp_next;
  logic [CNT_W-1:0]   wp_next;
  plan_t              plan;
  logic [POS_W-1:0]   wr_addr;
  logic               rd_bit;
  logic               dp_start;
  logic               dp_free;
  logic               bank_we;

  assign accept = in_valid_i && in_ready_o;
  assign ncbps  = ncbps_of(mod_q);
  assign plan   = depunct_plan(rate_q, phase_q);

  // Read of the held symbol first, then the write; a completed fill swaps
  // the banks and restarts the read of the new held symbol.
  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    bank_d     = bank_q;
    held_d     = held_q;
    phase_d    = phase_q;
    has_read_d = has_read_q;
    wr_pend_d  = wr_pend_q;
    req_d      = req_q;
    rd_en      = 1'b0;
    addr_load  = 1'b0;
    j_pos      = (CNT_W'(wp_q) >= ncbps) ? '0 : wp_q;
    rp_next    = CNT_W'(rp_q) + CNT_W'(1);
    wp_next    = CNT_W'(j_pos) + CNT_W'(1);
    if (accept) begin
      has_read_d = 1'b0;
      wr_pend_d  = 1'b0;
      unique case (command_e'(command_i))
        CMD_BIT,
        CMD_DRAIN: begin
          if (held_q) begin
            if (CNT_W'(rp_q) >= ncbps) begin
              // symbol shortened by a modulation change: end it quietly
              held_d = 1'b0;
              rp_d   = '0;
            end else begin
              rd_en      = 1'b1;
              has_read_d = 1'b1;
              phase_d    = plan.next_phase;
              req_d.lead  = plan.lead;
              req_d.trail = plan.trail;
              req_d.done  = (rp_next == ncbps);
              if (rp_next == ncbps) begin
                held_d = 1'b0;
                rp_d   = '0;
              end else begin
                rp_d = rp_next[POS_W-1:0];
              end
            end
          end
          if (command_e'(command_i) == CMD_BIT) begin
            wr_pend_d = 1'b1;
            addr_load = 1'b1;
            if (wp_next == ncbps) begin
              wp_d   = '0;
              bank_d = ~bank_q;
              held_d = 1'b1;
              rp_d   = '0;
            end else begin
              wp_d = wp_next[POS_W-1:0];
            end
          end
        end
        CMD_START: begin
          wp_d    = '0;
          rp_d    = '0;
          bank_d  = 1'b0;
          held_d  = 1'b0;
          phase_d = '0;
        end
        default: begin
          // unused command: drop it
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (has_read_d || wr_pend_d)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!has_read_q || dp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs: the write repeats harmlessly while the load stalls
  always_comb begin
    in_ready_o = 1'b0;
    dp_start   = 1'b0;
    bank_we    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_LOAD: begin
        dp_start = has_read_q && dp_free;
        bank_we  = wr_pend_q;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mod_q      <= MOD_BPSK;
      rate_q     <= '0;
      wp_q       <= '0;
      rp_q       <= '0;
      bank_q     <= 1'b0;
      held_q     <= 1'b0;
      phase_q    <= '0;
      has_read_q <= 1'b0;
      wr_pend_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      bank_q     <= bank_d;
      held_q     <= held_d;
      phase_q    <= phase_d;
      has_read_q <= has_read_d;
      wr_pend_q  <= wr_pend_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MODULATION: mod_q  <= modulation_e'(cfg_wdata_i);
          CFG_CODE_RATE:  rate_q <= cfg_wdata_i;
          default:        rate_q <= rate_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (accept) begin
      wbank_q <= bank_q;
      wbit_q  <= coded_bit_i;
    end
  end

  odd_addr u_addr (
    .clk_i  (clk_i),
    .load_i (addr_load),
    .pos_i  (j_pos),
    .mod_i  (mod_q),
    .addr_o (wr_addr)
  );

  odd_bank u_bank (
    .clk_i     (clk_i),
    .wr_en_i   (bank_we),
    .wr_bank_i (wbank_q),
    .wr_pos_i  (wr_addr),
    .wr_bit_i  (wbit_q),
    .rd_en_i   (rd_en),
    .rd_bank_i (~bank_q),
    .rd_pos_i  (rp_q),
    .rd_bit_o  (rd_bit)
  );

  odd_depunct u_depunct (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (dp_start),
    .req_i         (req_q),
    .bit_i         (rd_bit),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .symbol_o      (decoded_symbol_o),
    .symbol_done_o (symbol_done_o),
    .last_o        (last_of_run_o),
    .free_o        (dp_free)
  );

endmodule

/* hdl/odd_checker.sv */
// Port-level checks on the result stream of the deinterleaver/depuncturer,
// bound to the top level below. Uses odd_pkg.
module odd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] decoded_symbol_o,
  input logic       symbol_done_o,
  input logic       last_of_run_o
);
  import odd_pkg::*;

  // only a received bit or an erasure ever leaves the block
  a_symbol_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> decoded_symbol_o <= SYM_ERASURE)
    else $error("result code out of range");

  // a symbol ends only on the last result of its request
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_done_o |-> last_of_run_o)
    else $error("symbol end flagged before end of run");

  // the results of one request leave without a gap
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("result run broken off");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(decoded_symbol_o)
      && $stable(last_of_run_o) && $stable(symbol_done_o))
    else $error("stalled result changed");

endmodule

bind ofdm_deinterleave_depuncture odd_checker u_odd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .decoded_symbol_o (decoded_symbol_o),
  .symbol_done_o    (symbol_done_o),
  .last_of_run_o    (last_of_run_o)
);
